>>> sv/expression_char_tokenizer_macros.svh
// Assertion macros shared by the tokenizer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef EXPRESSION_CHAR_TOKENIZER_MACROS_SVH
`define EXPRESSION_CHAR_TOKENIZER_MACROS_SVH

// Implication checked every cycle outside reset.
`define ECT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer implication check failed");

// Consequence checked in the cycle after the antecedent, outside reset.
`define ECT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer next-cycle check failed");

// Check of the cycle after reset is applied.
`define ECT_ASSERT_RST(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("tokenizer reset check failed");

`endif

>>> sv/ect_pkg.sv
// Types, codes and constants of the expression tokenizer.
// No dependencies; imported by all tokenizer modules and the checker.
package ect_pkg;

    localparam int MAX_TOK = 4;
    localparam int CNT_W   = 3;

    typedef enum logic [2:0] {
        KIND_NUM   = 3'd0,
        KIND_VAR   = 3'd1,
        KIND_OP    = 3'd2,
        KIND_LPAR  = 3'd3,
        KIND_RPAR  = 3'd4,
        KIND_END   = 3'd5,
        KIND_EMPTY = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_NUM   = 2'd1,
        CLS_ALPHA = 2'd2
    } t_class;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_POW  = 2'd3;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       start;
        logic [1:0] prec;
    } t_token;

    typedef struct packed {
        t_token [MAX_TOK-1:0] tok;
        logic [CNT_W-1:0]     cnt;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic t_token mk_tok(t_kind kind, logic [7:0] ch, logic start,
                                      logic [1:0] prec);
        t_token t;
        t.kind  = kind;
        t.ch    = ch;
        t.start = start;
        t.prec  = prec;
        return t;
    endfunction

endpackage

>>> sv/ect_front.sv
// Front end: accepts characters, classifies them and builds the token run.
// Depends on ect_pkg; feeds ect_run_fifo.
module ect_front
    import ect_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_eot,
    input  t_fifo_stat i_stat,
    output logic       o_ready,
    output logic       o_push,
    output t_run       o_run
);

    t_class r_prev, n_prev;
    t_kind  r_last, n_last;

    logic             accept;
    logic [CNT_W-1:0] cnt;
    logic             is_digit, is_alpha;

    assign o_ready = !i_stat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (cnt != '0);

    always_comb begin
        is_digit = (i_char inside {["0":"9"]});
        is_alpha = (i_char inside {["a":"z"], ["A":"Z"]});
        o_run    = '0;
        cnt      = '0;
        n_prev   = r_prev;
        n_last   = r_last;
        if (is_digit) begin
            if (r_prev == CLS_NUM) begin
                o_run.tok[cnt[1:0]] = mk_tok(KIND_NUM, i_char, 1'b0, PREC_NONE);
                cnt = cnt + 1'b1;
            end else begin
                if (r_prev == CLS_ALPHA) begin
                    o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
                    cnt = cnt + 1'b1;
                end
                o_run.tok[cnt[1:0]] = mk_tok(KIND_NUM, i_char, 1'b1, PREC_NONE);
                cnt = cnt + 1'b1;
            end
            n_last = KIND_NUM;
            n_prev = CLS_NUM;
        end else if (i_char == CH_DOT && r_prev == CLS_NUM) begin
            o_run.tok[cnt[1:0]] = mk_tok(KIND_NUM, i_char, 1'b0, PREC_NONE);
            cnt    = cnt + 1'b1;
            n_last = KIND_NUM;
        end else if (is_alpha) begin
            if (r_prev == CLS_NUM) begin
                o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
                cnt = cnt + 1'b1;
            end
            o_run.tok[cnt[1:0]] = mk_tok(KIND_VAR, i_char, 1'b1, PREC_NONE);
            cnt    = cnt + 1'b1;
            n_last = KIND_VAR;
            n_prev = CLS_ALPHA;
        end else if (i_char == CH_LPAR) begin
            if (r_prev == CLS_NUM) begin
                o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
                cnt = cnt + 1'b1;
            end
            o_run.tok[cnt[1:0]] = mk_tok(KIND_LPAR, i_char, 1'b1, PREC_NONE);
            cnt    = cnt + 1'b1;
            n_last = KIND_LPAR;
            n_prev = CLS_NONE;
        end else if (i_char == CH_RPAR) begin
            o_run.tok[cnt[1:0]] = mk_tok(KIND_RPAR, i_char, 1'b1, PREC_NONE);
            cnt    = cnt + 1'b1;
            n_last = KIND_RPAR;
            n_prev = CLS_NONE;
        end else if (i_char == CH_PLUS) begin
            o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, i_char, 1'b1, PREC_ADD);
            cnt    = cnt + 1'b1;
            n_last = KIND_OP;
            n_prev = CLS_NONE;
        end else if (i_char == CH_MINUS) begin
            if (r_last == KIND_EMPTY || r_last == KIND_OP || r_last == KIND_LPAR) begin
                // unary minus: "-1" then '*'
                o_run.tok[cnt[1:0]] = mk_tok(KIND_NUM, CH_MINUS, 1'b1, PREC_NONE);
                cnt = cnt + 1'b1;
                o_run.tok[cnt[1:0]] = mk_tok(KIND_NUM, CH_ONE, 1'b0, PREC_NONE);
                cnt = cnt + 1'b1;
                o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
                cnt = cnt + 1'b1;
            end else begin
                o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, i_char, 1'b1, PREC_ADD);
                cnt = cnt + 1'b1;
            end
            n_last = KIND_OP;
            n_prev = CLS_NONE;
        end else if (i_char == CH_STAR || i_char == CH_SLASH) begin
            o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, i_char, 1'b1, PREC_MUL);
            cnt    = cnt + 1'b1;
            n_last = KIND_OP;
            n_prev = CLS_NONE;
        end else if (i_char == CH_CARET) begin
            o_run.tok[cnt[1:0]] = mk_tok(KIND_OP, i_char, 1'b1, PREC_POW);
            cnt    = cnt + 1'b1;
            n_last = KIND_OP;
            n_prev = CLS_NONE;
        end else begin
            n_prev = CLS_NONE;
        end
        if (i_eot) begin
            o_run.tok[cnt[1:0]] = mk_tok(KIND_END, CH_NUL, 1'b1, PREC_NONE);
            cnt    = cnt + 1'b1;
            n_prev = CLS_NONE;
            n_last = KIND_EMPTY;
        end
        o_run.cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= CLS_NONE;
            r_last <= KIND_EMPTY;
        end else if (accept) begin
            r_prev <= n_prev;
            r_last <= n_last;
        end
    end

endmodule

>>> sv/ect_run_fifo.sv
// Short queue of token runs between the front and back ends.
// Depends on ect_pkg.
module ect_run_fifo
    import ect_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_run       i_run,
    input  logic       i_pop,
    output t_run       o_head,
    output t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    t_run r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wptr, r_rptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/ect_back.sv
// Back end: walks the head run one token a beat into the output register.
// Depends on ect_pkg; reads ect_run_fifo.
module ect_back
    import ect_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_run       i_head,
    input  t_fifo_stat i_stat,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output t_token     o_tok,
    output logic       o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_token     r_tok;
    logic       r_last;

    logic load, take, at_end;

    assign load   = !r_valid || i_ready;
    assign take   = load && !i_stat.empty;
    assign at_end = ({1'b0, r_idx} == (i_head.cnt - 1'b1));
    assign o_pop  = take && at_end;

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok  <= i_head.tok[r_idx];
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_stat.empty;
            end
            if (take) begin
                r_idx <= at_end ? '0 : r_idx + 1'b1;
            end
        end
    end

endmodule

>>> sv/expression_char_tokenizer.sv
// Top level of the expression character tokenizer.
// Depends on ect_pkg, ect_front, ect_run_fifo and ect_back.
//
//  channel | dir | tdata                          | tuser                | tlast
//  s       | in  | [7:0] character                | -                    | end_of_text
//  m       | out | [7:0] token_char [9:8] precedence | [2:0] kind [3] start | last_of_run
//
// One character is accepted per cycle while the run queue has room.
// Each character yields 0 to 4 beats; the back end issues one beat per cycle
// while downstream is ready; the beats of a character pass through the run queue
// and then the output register.
// Reset (synchronous, active low) clears class state, queue and output register.
// The output register and the run queue let either side stall independently.
module expression_char_tokenizer
    import ect_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] character
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] token_char, [9:8] precedence, rest zero
    output logic [3:0]  o_m_tuser,   // [2:0] token_kind, [3] token_start
    output logic        o_m_tlast
);

    t_fifo_stat stat;
    t_run       run, head;
    logic       push, pop;
    t_token     tok;

    ect_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_char  (i_s_tdata),
        .i_eot   (i_s_tlast),
        .i_stat  (stat),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_run   (run)
    );

    ect_run_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    ect_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (stat),
        .i_ready (i_m_tready),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .o_tok   (tok),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {6'b0, tok.prec, tok.ch};
    assign o_m_tuser = {tok.start, tok.kind};

endmodule

>>> sv/ect_checker.sv
// Port-level checker for the tokenizer, bound to the top level.
// Depends on ect_pkg and expression_char_tokenizer_macros.svh.
`include "expression_char_tokenizer_macros.svh"

module ect_checker
    import ect_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [3:0]  o_m_tuser,
    input logic        o_m_tlast
);

    logic        s_take;
    logic        m_stall;
    logic [20:0] m_beat;
    logic        m_end, m_end_ok;
    logic        m_prec, m_op_start;

    assign s_take     = i_s_tvalid && o_s_tready;
    assign m_stall    = o_m_tvalid && !i_m_tready;
    assign m_beat     = {o_m_tdata, o_m_tuser, o_m_tlast};
    assign m_end      = o_m_tvalid && (o_m_tuser[2:0] == KIND_END);
    assign m_end_ok   = o_m_tlast && o_m_tuser[3] && (o_m_tdata[7:0] == CH_NUL);
    assign m_prec     = o_m_tvalid && (o_m_tdata[9:8] != PREC_NONE);
    assign m_op_start = (o_m_tuser[2:0] == KIND_OP) && o_m_tuser[3];

    `ECT_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, m_stall, o_m_tvalid && $stable(m_beat))
    `ECT_ASSERT_RST(a_reset_idle, i_clk, i_rst_n, !o_m_tvalid && o_s_tready)
    `ECT_ASSERT_IMP(a_end_beat, i_clk, i_rst_n, m_end, m_end_ok)
    `ECT_ASSERT_IMP(a_prec_op, i_clk, i_rst_n, m_prec, m_op_start)
    `ECT_ASSERT_IMP(a_in_known, i_clk, i_rst_n, s_take, !$isunknown({i_s_tdata, i_s_tlast}))

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

>>> sim/expression_char_tokenizer_test.sv
// Self-checking testbench for expression_char_tokenizer: directed table, then random text.
// Depends on ect_pkg and the tokenizer RTL; expected beats come from an in-bench lexer.
module expression_char_tokenizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ect_pkg::*;

    localparam int RANDOM_CHARS = 200;
    localparam int CALM_CHARS   = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        t_token tok;
        logic   last;
    } token_beat_t;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        int         n_typed;
        t_kind      kind;
        logic [7:0] tch;
        logic [1:0] prec;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] character
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;    // [7:0] token_char, [9:8] precedence
    logic [3:0]  o_m_tuser;    // [2:0] token_kind, [3] token_start
    logic        o_m_tlast;

    t_class      lex_class;
    t_kind       lex_last;
    t_token      run_toks[$];
    token_beat_t expected_beats[$];
    stim_row_t   directed[$];

    logic        calm;
    int          errors;
    int          chars_sent;
    int          beats_seen;
    int          ends_seen;
    int          cycles;

    expression_char_tokenizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("expression_char_tokenizer regression: fail");
            $finish;
        end
    end

    function automatic void emit(t_kind kind, logic [7:0] ch, logic start, logic [1:0] prec);
        run_toks.push_back(mk_tok(kind, ch, start, prec));
        lex_last = kind;
    endfunction

    // Tokens caused by one character; updates the lexer state.
    function automatic void lex_char(logic [7:0] c, logic eot);
        run_toks.delete();
        if (c >= "0" && c <= "9") begin
            if (lex_class == CLS_NUM) begin
                emit(KIND_NUM, c, 1'b0, PREC_NONE);
            end else begin
                if (lex_class == CLS_ALPHA)
                    emit(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
                emit(KIND_NUM, c, 1'b1, PREC_NONE);
            end
            lex_class = CLS_NUM;
        end else if (c == CH_DOT && lex_class == CLS_NUM) begin
            emit(KIND_NUM, c, 1'b0, PREC_NONE);
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            if (lex_class == CLS_NUM)
                emit(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
            emit(KIND_VAR, c, 1'b1, PREC_NONE);
            lex_class = CLS_ALPHA;
        end else if (c == CH_LPAR) begin
            if (lex_class == CLS_NUM)
                emit(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
            emit(KIND_LPAR, c, 1'b1, PREC_NONE);
            lex_class = CLS_NONE;
        end else if (c == CH_RPAR) begin
            emit(KIND_RPAR, c, 1'b1, PREC_NONE);
            lex_class = CLS_NONE;
        end else if (c == CH_PLUS) begin
            emit(KIND_OP, c, 1'b1, PREC_ADD);
            lex_class = CLS_NONE;
        end else if (c == CH_MINUS) begin
            if (lex_last == KIND_EMPTY || lex_last == KIND_OP || lex_last == KIND_LPAR) begin
                emit(KIND_NUM, CH_MINUS, 1'b1, PREC_NONE);
                emit(KIND_NUM, CH_ONE, 1'b0, PREC_NONE);
                emit(KIND_OP, CH_STAR, 1'b1, PREC_MUL);
            end else begin
                emit(KIND_OP, c, 1'b1, PREC_ADD);
            end
            lex_class = CLS_NONE;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            emit(KIND_OP, c, 1'b1, PREC_MUL);
            lex_class = CLS_NONE;
        end else if (c == CH_CARET) begin
            emit(KIND_OP, c, 1'b1, PREC_POW);
            lex_class = CLS_NONE;
        end else begin
            lex_class = CLS_NONE;
        end
        if (eot) begin
            emit(KIND_END, CH_NUL, 1'b1, PREC_NONE);
            lex_class = CLS_NONE;
            lex_last  = KIND_EMPTY;
        end
    endfunction

    function automatic stim_row_t p_row(logic [7:0] ch, logic eot);
        stim_row_t r;
        r = '{ch, eot, 1'b0, 0, KIND_NUM, CH_NUL, PREC_NONE};
        return r;
    endfunction

    function automatic stim_row_t t_row(logic [7:0] ch, logic eot, int n, t_kind kind,
                                        logic [7:0] tch, logic [1:0] prec);
        stim_row_t r;
        r = '{ch, eot, 1'b1, n, kind, tch, prec};
        return r;
    endfunction

    // Expression-like text with some noise bytes.
    function automatic logic [7:0] pick_char();
        int unsigned r;
        logic [7:0]  ops[6];
        ops = '{CH_PLUS, CH_MINUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
        r = $urandom_range(0, 99);
        if (r < 30) return 8'(8'h30 + $urandom_range(0, 9));
        if (r < 48) return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
        if (r < 68) return ops[$urandom_range(0, 5)];
        if (r < 78) return $urandom_range(0, 1) ? CH_LPAR : CH_RPAR;
        if (r < 84) return CH_DOT;
        if (r < 90) return $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_char(stim_row_t row);
        int unsigned gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = row.ch;
        i_s_tlast  = row.eot;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
        lex_char(row.ch, row.eot);
        if (row.typed) begin
            run_toks.delete();
            if (row.n_typed == 1)
                run_toks.push_back(mk_tok(row.kind, row.tch, 1'b1, row.prec));
        end
        foreach (run_toks[k])
            expected_beats.push_back('{run_toks[k], k == run_toks.size() - 1});
    endtask

    task automatic report(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_beat
        token_beat_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            beats_seen++;
            if (o_m_tuser[2:0] == KIND_END)
                ends_seen++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual tdata=%h tuser=%h tlast=%b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (o_m_tuser[2:0] !== want.tok.kind)
                    report("token_kind", 8'(want.tok.kind), 8'(o_m_tuser[2:0]));
                if (o_m_tdata[7:0] !== want.tok.ch)
                    report("token_char", want.tok.ch, o_m_tdata[7:0]);
                if (o_m_tuser[3] !== want.tok.start)
                    report("token_start", 8'(want.tok.start), 8'(o_m_tuser[3]));
                if (o_m_tdata[9:8] !== want.tok.prec)
                    report("precedence", 8'(want.tok.prec), 8'(o_m_tdata[9:8]));
                if (o_m_tlast !== want.last)
                    report("last_of_run", 8'(want.last), 8'(o_m_tlast));
                if (o_m_tdata[15:10] !== 6'd0)
                    report("tdata pad", 8'h00, 8'(o_m_tdata[15:10]));
            end
        end
    end

    // Downstream stalls in random bursts until the calm tail.
    initial begin : sink
        int unsigned stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_tready = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    initial begin : stimulus
        int drain;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tlast  = 1'b0;
        calm       = 1'b0;
        errors     = 0;
        chars_sent = 0;
        beats_seen = 0;
        ends_seen  = 0;
        cycles     = 0;
        lex_class  = CLS_NONE;
        lex_last   = KIND_EMPTY;

        directed.push_back(p_row(CH_MINUS, 1'b0));             // unary minus right after reset
        directed.push_back(p_row("9", 1'b0));
        directed.push_back(p_row(CH_DOT, 1'b0));
        directed.push_back(p_row("0", 1'b0));
        directed.push_back(p_row("x", 1'b0));                  // number then letter
        directed.push_back(p_row("7", 1'b0));                  // letter then digit
        directed.push_back(p_row(CH_LPAR, 1'b0));              // number then paren
        directed.push_back(p_row(CH_MINUS, 1'b0));             // unary after '('
        directed.push_back(p_row("Z", 1'b0));
        directed.push_back(t_row(CH_RPAR, 1'b0, 1, KIND_RPAR, CH_RPAR, PREC_NONE));
        directed.push_back(t_row(CH_MINUS, 1'b0, 1, KIND_OP, CH_MINUS, PREC_ADD));
        directed.push_back(p_row("A", 1'b0));
        directed.push_back(t_row(CH_CARET, 1'b0, 1, KIND_OP, CH_CARET, PREC_POW));
        directed.push_back(t_row(CH_SLASH, 1'b0, 1, KIND_OP, CH_SLASH, PREC_MUL));
        directed.push_back(t_row(8'h20, 1'b0, 0, KIND_NUM, CH_NUL, PREC_NONE));
        directed.push_back(t_row(CH_DOT, 1'b0, 0, KIND_NUM, CH_NUL, PREC_NONE));
        directed.push_back(t_row(8'h80, 1'b0, 0, KIND_NUM, CH_NUL, PREC_NONE));
        directed.push_back(t_row(8'hFF, 1'b0, 0, KIND_NUM, CH_NUL, PREC_NONE));
        directed.push_back(t_row(CH_STAR, 1'b0, 1, KIND_OP, CH_STAR, PREC_MUL));
        directed.push_back(t_row(CH_NUL, 1'b1, 1, KIND_END, CH_NUL, PREC_NONE));
        directed.push_back(t_row(CH_LPAR, 1'b0, 1, KIND_LPAR, CH_LPAR, PREC_NONE));
        directed.push_back(p_row("1", 1'b0));
        directed.push_back(t_row(8'h09, 1'b0, 0, KIND_NUM, CH_NUL, PREC_NONE));
        directed.push_back(t_row("a", 1'b0, 1, KIND_VAR, "a", PREC_NONE));  // gap, no '*'
        directed.push_back(p_row(CH_MINUS, 1'b1));             // binary minus then end
        directed.push_back(p_row(CH_MINUS, 1'b1));             // four beats from one character

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[d])
            send_char(directed[d]);

        for (int n = 0; n < RANDOM_CHARS; n++) begin
            if (n >= RANDOM_CHARS - CALM_CHARS)
                calm = 1'b1;
            send_char(p_row(pick_char(), $urandom_range(0, 14) == 0));
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        i_s_tlast  = 1'b0;

        while (expected_beats.size() != 0)
            @(posedge i_clk);
        drain = 0;
        while (drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end

        $display("sent %0d characters (%0d directed), checked %0d token beats, %0d end tokens",
                 chars_sent, directed.size(), beats_seen, ends_seen);
        $display("%0d mismatches", errors);
        if (errors == 0) begin
            $display("expression_char_tokenizer regression: pass");
        end else begin
            $display("expression_char_tokenizer regression: fail");
        end
        $finish;
    end

endmodule

>>> expression_char_tokenizer.f
+incdir+sv
sv/ect_pkg.sv
sv/ect_front.sv
sv/ect_run_fifo.sv
sv/ect_back.sv
sv/expression_char_tokenizer.sv
sv/ect_checker.sv
sim/expression_char_tokenizer_test.sv
